### rtl/npcs_pkg.sv
// Shared types, constants and helpers for the nearest palette color search block.
package npcs_pkg;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int ENTRY_W = 3 * COLOR_W;
  localparam int SQ_W = 2 * COLOR_W;
  localparam int DIST_W = 18;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 + 256 * 256 + 256 * 256);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } scan_tag_t;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/npcs_palette_ram.sv
// Palette memory: one write port, one read port with registered read data.
module npcs_palette_ram #(
  parameter int DEPTH = npcs_pkg::PALETTE_ENTRIES_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [npcs_pkg::ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [npcs_pkg::ENTRY_W-1:0] rdata
);

  logic [npcs_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/npcs_dist.sv
// Distance pipeline: squared differences, sum, and running minimum over one scan.
module npcs_dist #(
  parameter int AW = npcs_pkg::INDEX_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  npcs_pkg::scan_tag_t          tag,
  input  logic [AW-1:0]                idx,
  input  logic [npcs_pkg::ENTRY_W-1:0] entry,
  input  logic [npcs_pkg::COLOR_W-1:0] q_red,
  input  logic [npcs_pkg::COLOR_W-1:0] q_green,
  input  logic [npcs_pkg::COLOR_W-1:0] q_blue,
  output logic                         busy,
  output logic                         done,
  output logic [AW-1:0]                best
);

  localparam int CW = npcs_pkg::COLOR_W;

  npcs_pkg::scan_tag_t      sq_tag;
  logic [AW-1:0]            sq_idx;
  logic [npcs_pkg::SQ_W-1:0] sq_r, sq_g, sq_b;
  logic [CW-1:0]            dr, dg, db;
  logic [npcs_pkg::DIST_W-1:0] sum, bound, best_dist;
  logic [AW-1:0]            best_idx, best_idx_next;
  logic                     take;

  assign dr = npcs_pkg::abs_diff(entry[3*CW-1:2*CW], q_red);
  assign dg = npcs_pkg::abs_diff(entry[2*CW-1:CW], q_green);
  assign db = npcs_pkg::abs_diff(entry[CW-1:0], q_blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tag <= '0;
    end else begin
      sq_tag <= tag;
    end
    sq_idx <= idx;
    sq_r   <= dr * dr;
    sq_g   <= dg * dg;
    sq_b   <= db * db;
  end

  assign sum = npcs_pkg::DIST_W'(sq_r) + npcs_pkg::DIST_W'(sq_g) + npcs_pkg::DIST_W'(sq_b);
  assign bound = sq_tag.first ? npcs_pkg::DIST_START : best_dist;
  assign take = sum < bound;
  assign best_idx_next = take ? sq_idx : best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_tag.valid && sq_tag.last;
    end
    if (sq_tag.valid) begin
      if (take) begin
        best_dist <= sum;
        best_idx  <= sq_idx;
      end
      if (sq_tag.last) begin
        best <= best_idx_next;
      end
    end
  end

  assign busy = sq_tag.valid;

endmodule

### rtl/nearest_palette_color_search.sv
// Top level of the nearest palette color search: request decode, scan sequencer, result.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-----------------------------------------
//   request   | start, busy             | command, entry_index, red, green, blue
//   result    | done (one-cycle strobe) | best_index
//
// A write request leaves busy low. A query request reads the palette memory
// once per entry through its single read port, and done rises once the last
// entry has passed the scan address, the registered read data, the squared
// differences and the done register; busy is high in between and the next
// request can be accepted in the done cycle. The result cannot be stalled.
// Reset clears control state only; the palette content is undefined until written.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [npcs_pkg::INDEX_W-1:0]      entry_index,
  input  logic [npcs_pkg::COLOR_W-1:0]      red,
  input  logic [npcs_pkg::COLOR_W-1:0]      green,
  input  logic [npcs_pkg::COLOR_W-1:0]      blue,
  output logic                              done,
  output logic [npcs_pkg::INDEX_W-1:0]      best_index
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  logic                         accept, wr_en, q_start;
  logic                         scan_active, dist_busy;
  logic [AW-1:0]                addr;
  npcs_pkg::scan_tag_t          rd_tag;
  logic [AW-1:0]                rd_idx, best;
  logic [npcs_pkg::ENTRY_W-1:0] rd_data;
  logic [npcs_pkg::COLOR_W-1:0] q_red, q_green, q_blue;

  assign accept  = start && !busy;
  assign q_start = accept && (npcs_pkg::cmd_t'(command) == npcs_pkg::CMD_QUERY);
  assign wr_en   = accept && (npcs_pkg::cmd_t'(command) == npcs_pkg::CMD_WRITE)
                   && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      addr        <= '0;
      rd_tag      <= '0;
    end else begin
      rd_tag.valid <= scan_active;
      rd_tag.first <= scan_active && (addr == '0);
      rd_tag.last  <= scan_active && (addr == LAST_ADDR);
      if (q_start) begin
        scan_active <= 1'b1;
        addr        <= '0;
      end else if (scan_active) begin
        if (addr == LAST_ADDR) begin
          scan_active <= 1'b0;
        end
        addr <= addr + AW'(1);
      end
    end
    rd_idx <= addr;
    if (q_start) begin
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
    end
  end

  npcs_palette_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_index[AW-1:0]),
    .wdata ({red, green, blue}),
    .raddr (addr),
    .rdata (rd_data)
  );

  npcs_dist #(
    .AW (AW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag     (rd_tag),
    .idx     (rd_idx),
    .entry   (rd_data),
    .q_red   (q_red),
    .q_green (q_green),
    .q_blue  (q_blue),
    .busy    (dist_busy),
    .done    (done),
    .best    (best)
  );

  assign busy       = scan_active || rd_tag.valid || dist_busy;
  assign best_index = npcs_pkg::INDEX_W'(best);

  a_query_busy: assert property (@(posedge clk) disable iff (rst) q_start |=> busy)
    else $error("query request did not raise busy");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && !q_start) |=> !busy)
    else $error("write request left block busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while scan still running");
  a_done_past: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a query in flight");

endmodule
